// ----- hw/rtl/nearest_target_mode_selector_unit_defines.svh -----
// Assertion macros used by the nearest target mode selector RTL.
`ifndef NEAREST_TARGET_MODE_SELECTOR_UNIT_DEFINES_SVH
`define NEAREST_TARGET_MODE_SELECTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define NTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define NTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NTS_ASSERT_IMP(label, ante, cons, msg)
`define NTS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/nts_pkg.sv -----
// Types, constants and helper functions of the nearest target mode selector.
package nts_pkg;

    localparam int COORD_BITS    = 16;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int DIST_BITS     = 2 * COORD_BITS + 2;
    localparam int RAD_BITS      = 16;
    localparam int RAD_SQ_BITS   = 2 * RAD_BITS;
    localparam int HOLD_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS;

    // Command codes of an input item.
    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Mode codes of a result item.
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_AIM    = 2'd1;
    localparam logic [1:0] MODE_ATTACK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_HOME_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOME_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS = 3'd5;

    // Reset values of the radius registers, kept as squares, and of the hold count.
    localparam int GREEN_RESET    = 2000;
    localparam int RED_RESET      = 1000;
    localparam int DEADZONE_RESET = 500;
    localparam logic [RAD_SQ_BITS-1:0] GREEN_SQ_RESET    = RAD_SQ_BITS'(GREEN_RESET * GREEN_RESET);
    localparam logic [RAD_SQ_BITS-1:0] RED_SQ_RESET      = RAD_SQ_BITS'(RED_RESET * RED_RESET);
    localparam logic [RAD_SQ_BITS-1:0] DEADZONE_SQ_RESET =
        RAD_SQ_BITS'(DEADZONE_RESET * DEADZONE_RESET);
    localparam logic [HOLD_BITS-1:0]   HOLD_TICKS_RESET  = HOLD_BITS'(1500);

    typedef struct packed {
        logic [1:0]                    cmd;
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic signed [COORD_BITS-1:0]  robot_x;
        logic signed [COORD_BITS-1:0]  robot_y;
        logic                          in_circle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                    mode;
        logic                          target_valid;
        logic signed [COORD_BITS-1:0]  tgt_x;
        logic signed [COORD_BITS-1:0]  tgt_y;
    } out_item_t;

    // Configuration as seen by the datapath; radii are held squared.
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  home_x;
        logic signed [COORD_BITS-1:0]  home_y;
        logic [RAD_SQ_BITS-1:0]        green_sq;
        logic [RAD_SQ_BITS-1:0]        red_sq;
        logic [RAD_SQ_BITS-1:0]        deadzone_sq;
        logic [HOLD_BITS-1:0]          hold_ticks;
    } cfg_t;

    // Item after the squaring stage.
    typedef struct packed {
        logic [1:0]                    cmd;
        logic                          in_circle;
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic [SQ_BITS-1:0]            home_dx_sq;
        logic [SQ_BITS-1:0]            home_dy_sq;
        logic [SQ_BITS-1:0]            robot_dx_sq;
        logic [SQ_BITS-1:0]            robot_dy_sq;
    } sq_item_t;

    // Magnitude of the difference of two signed coordinates.
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0]        m;
        d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
        m = d[COORD_BITS] ? (COORD_BITS + 1)'(-d) : (COORD_BITS + 1)'(d);
        return m[COORD_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/nts_cfg.sv -----
// Configuration register file; radius writes are stored squared.
module nts_cfg
    import nts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [RAD_BITS-1:0]    radius;
    logic [RAD_SQ_BITS-1:0] radius_sq;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // One shared squarer for the three radius registers.
    assign radius    = cfg_data[RAD_BITS-1:0];
    assign radius_sq = RAD_SQ_BITS'(radius) * RAD_SQ_BITS'(radius);

    // Register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOME_X:     cfg_next.home_x      = cfg_data[COORD_BITS-1:0];
                REG_HOME_Y:     cfg_next.home_y      = cfg_data[COORD_BITS-1:0];
                REG_GREEN:      cfg_next.green_sq    = radius_sq;
                REG_RED:        cfg_next.red_sq      = radius_sq;
                REG_DEADZONE:   cfg_next.deadzone_sq = radius_sq;
                REG_HOLD_TICKS: cfg_next.hold_ticks  = cfg_data[HOLD_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_x      <= '0;
            cfg_reg.home_y      <= '0;
            cfg_reg.green_sq    <= GREEN_SQ_RESET;
            cfg_reg.red_sq      <= RED_SQ_RESET;
            cfg_reg.deadzone_sq <= DEADZONE_SQ_RESET;
            cfg_reg.hold_ticks  <= HOLD_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/nts_sq.sv -----
// Input register and squaring stage for the two point distances.
module nts_sq
    import nts_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  in_item_t                      item,
    input  logic signed [COORD_BITS-1:0]  home_x,
    input  logic signed [COORD_BITS-1:0]  home_y,
    output logic                          sq_valid,
    input  logic                          sq_ready,
    output sq_item_t                      sq_item
);

    logic            in_valid_reg;
    in_item_t        in_reg;
    logic            sq_valid_reg;
    sq_item_t        sq_reg;
    sq_item_t        sq_next;
    logic            sq_load;
    logic            in_load;
    logic [COORD_BITS-1:0] hdx;
    logic [COORD_BITS-1:0] hdy;
    logic [COORD_BITS-1:0] rdx;
    logic [COORD_BITS-1:0] rdy;

    // Each stage moves on when it is empty or its contents move on.
    assign sq_load    = !sq_valid_reg || sq_ready;
    assign item_ready = !in_valid_reg || sq_load;
    assign in_load    = item_valid && item_ready;

    // Coordinate differences and their squares.
    assign hdx = abs_diff(home_x, in_reg.point_x);
    assign hdy = abs_diff(home_y, in_reg.point_y);
    assign rdx = abs_diff(in_reg.point_x, in_reg.robot_x);
    assign rdy = abs_diff(in_reg.point_y, in_reg.robot_y);

    always_comb
    begin
        sq_next.cmd         = in_reg.cmd;
        sq_next.in_circle   = in_reg.in_circle;
        sq_next.point_x     = in_reg.point_x;
        sq_next.point_y     = in_reg.point_y;
        sq_next.home_dx_sq  = SQ_BITS'(hdx) * SQ_BITS'(hdx);
        sq_next.home_dy_sq  = SQ_BITS'(hdy) * SQ_BITS'(hdy);
        sq_next.robot_dx_sq = SQ_BITS'(rdx) * SQ_BITS'(rdx);
        sq_next.robot_dy_sq = SQ_BITS'(rdy) * SQ_BITS'(rdy);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (sq_load)
            begin
                sq_valid_reg <= in_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= item;
        end
        if (sq_load && in_valid_reg)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq_valid = sq_valid_reg;
    assign sq_item  = sq_reg;

endmodule

// ----- hw/rtl/nts_select.sv -----
// Nearest candidate search, hold timer, mode bands and result register.
`include "nearest_target_mode_selector_unit_defines.svh"

module nts_select
    import nts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sq_valid,
    output logic       sq_ready,
    input  sq_item_t   sq_item,
    input  cfg_t       cfg,
    output logic       result_valid,
    input  logic       result_ready,
    output out_item_t  result
);

    logic                          go;
    logic [DIST_BITS-1:0]          robot_dsq;
    logic [DIST_BITS-1:0]          home_dsq;
    logic                          take_point;
    logic [1:0]                    band_mode;

    logic [DIST_BITS-1:0]          best_dist_sq_reg, best_dist_sq_next;
    logic                          best_found_reg, best_found_next;
    logic signed [COORD_BITS-1:0]  best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0]  best_y_reg, best_y_next;
    logic signed [COORD_BITS-1:0]  active_x_reg, active_x_next;
    logic signed [COORD_BITS-1:0]  active_y_reg, active_y_next;
    logic                          active_valid_reg, active_valid_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [HOLD_BITS-1:0]          hold_reg, hold_next;
    logic                          res_valid_reg, res_valid_next;
    out_item_t                     res_reg, res_next;

    // Only a scan end needs the result register free.
    assign sq_ready = (sq_item.cmd != CMD_END) || !res_valid_reg || result_ready;
    assign go       = sq_valid && sq_ready;

    // Squared distances to the robot and to home.
    assign robot_dsq = DIST_BITS'(sq_item.robot_dx_sq) + DIST_BITS'(sq_item.robot_dy_sq);
    assign home_dsq  = DIST_BITS'(sq_item.home_dx_sq) + DIST_BITS'(sq_item.home_dy_sq);

    // A circle point outside the deadzone that beats the candidate; ties keep the first.
    assign take_point = sq_item.in_circle
                     && (robot_dsq >= DIST_BITS'(cfg.deadzone_sq))
                     && (!best_found_reg || (home_dsq < best_dist_sq_reg));

    // Mode band of the current candidate.
    always_comb
    begin
        if (best_dist_sq_reg >= DIST_BITS'(cfg.green_sq))
        begin
            band_mode = MODE_WAIT;
        end
        else if (best_dist_sq_reg >= DIST_BITS'(cfg.red_sq))
        begin
            band_mode = MODE_AIM;
        end
        else
        begin
            band_mode = MODE_ATTACK;
        end
    end

    // Next state for the item in this stage.
    always_comb
    begin
        best_dist_sq_next = best_dist_sq_reg;
        best_found_next   = best_found_reg;
        best_x_next       = best_x_reg;
        best_y_next       = best_y_reg;
        active_x_next     = active_x_reg;
        active_y_next     = active_y_reg;
        active_valid_next = active_valid_reg;
        mode_next         = mode_reg;
        hold_next         = hold_reg;
        res_valid_next    = res_valid_reg && !result_ready;
        res_next          = res_reg;

        if (go)
        begin
            case (sq_item.cmd)
                CMD_POINT:
                begin
                    if (take_point)
                    begin
                        best_dist_sq_next = home_dsq;
                        best_found_next   = 1'b1;
                        best_x_next       = sq_item.point_x;
                        best_y_next       = sq_item.point_y;
                    end
                end
                CMD_TICK:
                begin
                    if (hold_reg != '0)
                    begin
                        hold_next = hold_reg - HOLD_BITS'(1);
                    end
                end
                CMD_END:
                begin
                    // Re-evaluate only once the hold has run out.
                    if (hold_reg == '0)
                    begin
                        if (!best_found_reg)
                        begin
                            active_valid_next = 1'b0;
                            mode_next         = MODE_WAIT;
                        end
                        else
                        begin
                            active_x_next     = best_x_reg;
                            active_y_next     = best_y_reg;
                            active_valid_next = 1'b1;
                            hold_next         = cfg.hold_ticks;
                            mode_next         = band_mode;
                        end
                    end
                    best_dist_sq_next = '1;
                    best_found_next   = 1'b0;
                    best_x_next       = '0;
                    best_y_next       = '0;

                    res_valid_next        = 1'b1;
                    res_next.mode         = mode_next;
                    res_next.target_valid = active_valid_next;
                    res_next.tgt_x        = active_valid_next ? active_x_next : '0;
                    res_next.tgt_y        = active_valid_next ? active_y_next : '0;
                end
                default:
                begin
                    res_valid_next = res_valid_reg && !result_ready;
                end
            endcase
        end
    end

    // Search, target and hold state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_sq_reg <= '1;
            best_found_reg   <= 1'b0;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
            active_x_reg     <= '0;
            active_y_reg     <= '0;
            active_valid_reg <= 1'b0;
            mode_reg         <= MODE_WAIT;
            hold_reg         <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            best_dist_sq_reg <= best_dist_sq_next;
            best_found_reg   <= best_found_next;
            best_x_reg       <= best_x_next;
            best_y_reg       <= best_y_next;
            active_x_reg     <= active_x_next;
            active_y_reg     <= active_y_next;
            active_valid_reg <= active_valid_next;
            mode_reg         <= mode_next;
            hold_reg         <= hold_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // A running hold always belongs to a latched target.
    `NTS_ASSERT_IMP(a_hold_has_target, hold_reg != '0, active_valid_reg,
        "hold running without a latched target")
    // A result without a target carries zero coordinates.
    `NTS_ASSERT_IMP(a_empty_result_zero, res_valid_reg && !res_reg.target_valid,
        res_reg.tgt_x == '0 && res_reg.tgt_y == '0,
        "result without target has nonzero coordinates")
    // A scan end always leaves the search cleared.
    `NTS_ASSERT_NXT(a_end_clears_search, go && sq_item.cmd == CMD_END,
        !best_found_reg && best_dist_sq_reg == '1,
        "search not cleared after scan end")
    // A tick on a running hold counts it down by one.
    `NTS_ASSERT_NXT(a_tick_counts_down, go && sq_item.cmd == CMD_TICK && hold_reg != '0,
        hold_reg == $past(hold_reg) - HOLD_BITS'(1),
        "hold did not count down on tick")
    // A new result appears only after a scan end was processed.
    `NTS_ASSERT_IMP(a_result_from_end, $rose(res_valid_reg),
        $past(go) && $past(sq_item.cmd) == CMD_END,
        "result raised without a scan end")

endmodule

// ----- hw/rtl/nearest_target_mode_selector_unit.sv -----
// Top level of the nearest target mode selector.
//
// Items arrive on the item channel (valid/ready): scan points, scan ends and
// time ticks. Only a scan end produces a result, which leaves on the result
// channel (valid/ready) with the mode and the latched target. Registers are
// written through the cfg channel, whose ready is always high; write only
// while no item is in flight.
//
// Throughput: one item per cycle, but a scan end stalls while a result is still
// pending. A scan end's transfer loads the input register, then the squaring
// register and the result register follow. The squaring stage with its four
// 16x16 multipliers sets the middle register; the compare against the running
// candidate sits in the last stage, where the search state lives.
//
// Reset clears the search, the latched target and the hold timer, and loads
// the register defaults. When the receiver stalls, points and ticks keep
// flowing; a scan end waits in the last stage until the pending result is
// taken, and the stages behind it fill before item_ready drops.
module nearest_target_mode_selector_unit
    import nts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  in_item_t                  item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output out_item_t                 result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t     cfg;
    logic     sq_valid;
    logic     sq_ready;
    sq_item_t sq_item;

    // Configuration registers.
    nts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and distance squaring.
    nts_sq u_sq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .home_x     (cfg.home_x),
        .home_y     (cfg.home_y),
        .sq_valid   (sq_valid),
        .sq_ready   (sq_ready),
        .sq_item    (sq_item)
    );

    // Candidate search, hold rule and result register.
    nts_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .sq_valid     (sq_valid),
        .sq_ready     (sq_ready),
        .sq_item      (sq_item),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
